// ===== hdl/tws_pkg.sv =====
// Package with the shared types and codes of the three-wire 9-bit serial master.
`default_nettype none
package tws_pkg;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned WORD_W = 9;
  localparam int unsigned BYTE_W = 8;
  localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd200;

  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] STEP_LOW   = 2'd0;
  localparam logic [1:0] STEP_SETUP = 2'd1;
  localparam logic [1:0] STEP_HIGH  = 2'd2;
  localparam logic [1:0] STEP_TAIL  = 2'd3;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'b001,
    MODE_WRITE = 3'b010,
    MODE_READ  = 3'b100
  } mode_t;

  typedef struct packed {
    logic              rejected;
    logic [BYTE_W-1:0] read_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_drive;
    logic              sda_out;
    logic              scl;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/three_wire_9bit_serial_master_top.sv =====
// Top level of the three-wire 9-bit serial master: stream ports, phase register and result register.
// The result of an item appears in the output register in the cycle after it is accepted.
// Throughput: one item per cycle; while a result waits, an item is taken only as that result leaves.
// The rate is set by the single pass through the sequencer between input and result register.
// Reset (rst_n, synchronous, active low) clears the transfer state, empties the output register
// and sets the phase length back to 200 ticks.
`default_nettype none
module three_wire_9bit_serial_master_top #(
  parameter int unsigned WRITE_BITS = 9,
  parameter int unsigned READ_BITS  = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // word [8:0], sda_in [9], zero [15:10]
  input  wire logic [1:0]  in_tuser,   // kind [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // scl [0], sda_out [1], sda_drive [2], busy_res [3],
                                       // done_res [4], read_byte [12:5], rejected [13], zero [15:14]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // phase_ticks
);

  logic                           in_accept;
  logic [tws_pkg::PHASE_W-1:0]    phase_ticks_r;
  logic                           out_valid_r;
  tws_pkg::result_t               result;
  tws_pkg::result_t               out_res_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  tws_engine #(
    .WRITE_BITS (WRITE_BITS),
    .READ_BITS  (READ_BITS)
  ) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_accept),
    .kind        (in_tuser),
    .word        (in_tdata[8:0]),
    .sda_in      (in_tdata[9]),
    .phase_ticks (phase_ticks_r),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= tws_pkg::PHASE_TICKS_RST;
    end else if (cfg_valid) begin
      phase_ticks_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule
`default_nettype wire

// ===== hdl/tws_engine.sv =====
// Bus sequencer: holds the transfer state and works out the pin levels for each tick.
`default_nettype none
module tws_engine #(
  parameter int unsigned WRITE_BITS = 9,
  parameter int unsigned READ_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         step,
  input  wire logic [tws_pkg::KIND_W-1:0]   kind,
  input  wire logic [tws_pkg::WORD_W-1:0]   word,
  input  wire logic                         sda_in,
  input  wire logic [tws_pkg::PHASE_W-1:0]  phase_ticks,
  output tws_pkg::result_t                  result
);

  localparam int unsigned MAX_BITS = (WRITE_BITS > READ_BITS) ? WRITE_BITS : READ_BITS;
  localparam int unsigned BL_W = $clog2(MAX_BITS + 1);
  localparam int unsigned PW = tws_pkg::PHASE_W;

  tws_pkg::mode_t             mode_r, mode_nxt;
  logic [PW-1:0]              phase_count_r, phase_count_nxt;
  logic [1:0]                 phase_step_r, phase_step_nxt;
  logic [BL_W-1:0]            bits_left_r, bits_left_nxt;
  logic [WRITE_BITS-1:0]      shift_r, shift_nxt;
  logic                       clock_level_r, clock_level_nxt;
  logic                       data_level_r, data_level_nxt;
  logic                       data_drive_r, data_drive_nxt;
  logic [tws_pkg::BYTE_W-1:0] received_r, received_nxt;

  logic [PW-1:0]  limit;
  logic [PW:0]    count_inc;
  logic [BL_W-1:0] bits_dec;
  logic           rej;
  logic           done;

  always_comb begin
    limit = (phase_ticks == '0) ? PW'(1) : phase_ticks;
    count_inc = {1'b0, phase_count_r} + (PW+1)'(1);
    bits_dec = (bits_left_r != '0) ? (bits_left_r - BL_W'(1)) : bits_left_r;

    mode_nxt        = mode_r;
    phase_count_nxt = phase_count_r;
    phase_step_nxt  = phase_step_r;
    bits_left_nxt   = bits_left_r;
    shift_nxt       = shift_r;
    clock_level_nxt = clock_level_r;
    data_level_nxt  = data_level_r;
    data_drive_nxt  = data_drive_r;
    received_nxt    = received_r;
    rej  = 1'b0;
    done = 1'b0;

    if (mode_r != tws_pkg::MODE_IDLE) begin
      rej = (kind == tws_pkg::KIND_WRITE) || (kind == tws_pkg::KIND_READ);
      phase_count_nxt = count_inc[PW-1:0];
      if (count_inc >= {1'b0, limit}) begin
        phase_count_nxt = '0;
        if (phase_step_r == tws_pkg::STEP_TAIL) begin
          mode_nxt        = tws_pkg::MODE_IDLE;
          phase_step_nxt  = tws_pkg::STEP_LOW;
          clock_level_nxt = 1'b0;
          done            = 1'b1;
        end else if (mode_r == tws_pkg::MODE_WRITE && phase_step_r == tws_pkg::STEP_LOW) begin
          phase_step_nxt  = tws_pkg::STEP_SETUP;
          data_level_nxt  = shift_r[WRITE_BITS-1];
          shift_nxt       = {shift_r[WRITE_BITS-2:0], 1'b0};
          clock_level_nxt = 1'b0;
        end else if (mode_r == tws_pkg::MODE_WRITE
                     && phase_step_r == tws_pkg::STEP_SETUP) begin
          phase_step_nxt  = tws_pkg::STEP_HIGH;
          clock_level_nxt = 1'b1;
        end else if (mode_r == tws_pkg::MODE_READ && phase_step_r == tws_pkg::STEP_LOW) begin
          received_nxt    = {received_r[tws_pkg::BYTE_W-2:0], sda_in};
          phase_step_nxt  = tws_pkg::STEP_HIGH;
          clock_level_nxt = 1'b1;
        end else begin
          bits_left_nxt   = bits_dec;
          clock_level_nxt = 1'b0;
          phase_step_nxt  = (bits_dec == '0) ? tws_pkg::STEP_TAIL : tws_pkg::STEP_LOW;
        end
      end
    end else if (kind == tws_pkg::KIND_WRITE) begin
      mode_nxt        = tws_pkg::MODE_WRITE;
      shift_nxt       = WRITE_BITS'(word);
      bits_left_nxt   = BL_W'(WRITE_BITS);
      phase_step_nxt  = tws_pkg::STEP_LOW;
      phase_count_nxt = '0;
      clock_level_nxt = 1'b0;
      data_level_nxt  = 1'b0;
      data_drive_nxt  = 1'b1;
    end else if (kind == tws_pkg::KIND_READ) begin
      mode_nxt        = tws_pkg::MODE_READ;
      received_nxt    = '0;
      bits_left_nxt   = BL_W'(READ_BITS);
      phase_step_nxt  = tws_pkg::STEP_LOW;
      phase_count_nxt = '0;
      clock_level_nxt = 1'b0;
      data_drive_nxt  = 1'b0;
    end

    result.scl       = clock_level_nxt;
    result.sda_out   = data_drive_nxt & data_level_nxt;
    result.sda_drive = data_drive_nxt;
    result.busy_res  = (mode_nxt != tws_pkg::MODE_IDLE);
    result.done_res  = done;
    result.read_byte = received_nxt;
    result.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= tws_pkg::MODE_IDLE;
      phase_count_r <= '0;
      phase_step_r  <= tws_pkg::STEP_LOW;
      bits_left_r   <= '0;
      shift_r       <= '0;
      clock_level_r <= 1'b0;
      data_level_r  <= 1'b0;
      data_drive_r  <= 1'b0;
      received_r    <= '0;
    end else if (step) begin
      mode_r        <= mode_nxt;
      phase_count_r <= phase_count_nxt;
      phase_step_r  <= phase_step_nxt;
      bits_left_r   <= bits_left_nxt;
      shift_r       <= shift_nxt;
      clock_level_r <= clock_level_nxt;
      data_level_r  <= data_level_nxt;
      data_drive_r  <= data_drive_nxt;
      received_r    <= received_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_three_wire_9bit_serial_master_top.sv =====
// Self-checking testbench for the three-wire 9-bit serial master: stream stimulus and pin checks.
module tb_three_wire_9bit_serial_master_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WR_BITS = 9;
  localparam int RD_BITS = 8;
  localparam logic [tws_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // word [8:0], sda_in [9], zero [15:10]
  logic [1:0]  in_tuser;   // kind [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // scl, sda_out, sda_drive, busy_res, done_res, read_byte, rejected
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  three_wire_9bit_serial_master_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Shadow of the bus sequencer.
  logic [15:0]                ph_ticks;
  tws_pkg::mode_t             pm_mode;
  int unsigned                pm_count;
  logic [1:0]                 pm_step;
  int                         pm_bits;
  logic [WR_BITS-1:0]         pm_shift;
  logic                       pm_scl;
  logic                       pm_sda;
  logic                       pm_drive;
  logic [tws_pkg::BYTE_W-1:0] pm_rx;

  tws_pkg::result_t pins_due [$];
  tws_pkg::result_t seen;
  tws_pkg::result_t want;
  int      err_cnt;
  int      n_items;
  int      n_results;
  int      n_writes;
  int      n_reads;
  int      n_rejects;
  int      hold_cycles;
  bit      steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic tws_pkg::result_t next_pins(input logic [1:0] kind, input logic [8:0] word,
                                                 input logic sda);
    int unsigned      lim;
    tws_pkg::result_t r;
    logic             rej;
    logic             done;
    lim  = (ph_ticks == 16'd0) ? 1 : ph_ticks;
    rej  = 1'b0;
    done = 1'b0;
    if (pm_mode != tws_pkg::MODE_IDLE) begin
      if (kind == tws_pkg::KIND_WRITE || kind == tws_pkg::KIND_READ) rej = 1'b1;
      pm_count++;
      if (pm_count >= lim) begin
        pm_count = 0;
        if (pm_step == tws_pkg::STEP_TAIL) begin
          pm_mode = tws_pkg::MODE_IDLE;
          pm_step = tws_pkg::STEP_LOW;
          pm_scl  = 1'b0;
          done    = 1'b1;
        end else if (pm_mode == tws_pkg::MODE_WRITE && pm_step == tws_pkg::STEP_LOW) begin
          pm_step  = tws_pkg::STEP_SETUP;
          pm_sda   = pm_shift[WR_BITS-1];
          pm_shift = {pm_shift[WR_BITS-2:0], 1'b0};
          pm_scl   = 1'b0;
        end else if (pm_mode == tws_pkg::MODE_WRITE && pm_step == tws_pkg::STEP_SETUP) begin
          pm_step = tws_pkg::STEP_HIGH;
          pm_scl  = 1'b1;
        end else if (pm_mode == tws_pkg::MODE_READ && pm_step == tws_pkg::STEP_LOW) begin
          pm_rx   = {pm_rx[tws_pkg::BYTE_W-2:0], sda};
          pm_step = tws_pkg::STEP_HIGH;
          pm_scl  = 1'b1;
        end else begin
          if (pm_bits > 0) pm_bits--;
          pm_scl  = 1'b0;
          pm_step = (pm_bits == 0) ? tws_pkg::STEP_TAIL : tws_pkg::STEP_LOW;
        end
      end
    end else if (kind == tws_pkg::KIND_WRITE) begin
      pm_mode  = tws_pkg::MODE_WRITE;
      pm_shift = word;
      pm_bits  = WR_BITS;
      pm_step  = tws_pkg::STEP_LOW;
      pm_count = 0;
      pm_scl   = 1'b0;
      pm_sda   = 1'b0;
      pm_drive = 1'b1;
    end else if (kind == tws_pkg::KIND_READ) begin
      pm_mode  = tws_pkg::MODE_READ;
      pm_rx    = '0;
      pm_bits  = RD_BITS;
      pm_step  = tws_pkg::STEP_LOW;
      pm_count = 0;
      pm_scl   = 1'b0;
      pm_drive = 1'b0;
    end
    if (rej) n_rejects++;
    r.scl       = pm_scl;
    r.sda_out   = pm_drive ? pm_sda : 1'b0;
    r.sda_drive = pm_drive;
    r.busy_res  = (pm_mode != tws_pkg::MODE_IDLE);
    r.done_res  = done;
    r.read_byte = pm_rx;
    r.rejected  = rej;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    if (err_cnt < 200)
      $display("MISMATCH %s at result %0d: got %h, expected %h", what, n_results, got, exp_val);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = tws_pkg::result_t'(out_tdata[13:0]);
      if (pins_due.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 16'd0);
      end else begin
        want = pins_due.pop_front();
        if (seen.scl !== want.scl) report_mismatch("scl", 16'(seen.scl), 16'(want.scl));
        if (seen.sda_out !== want.sda_out)
          report_mismatch("sda_out", 16'(seen.sda_out), 16'(want.sda_out));
        if (seen.sda_drive !== want.sda_drive)
          report_mismatch("sda_drive", 16'(seen.sda_drive), 16'(want.sda_drive));
        if (seen.busy_res !== want.busy_res)
          report_mismatch("busy_res", 16'(seen.busy_res), 16'(want.busy_res));
        if (seen.done_res !== want.done_res)
          report_mismatch("done_res", 16'(seen.done_res), 16'(want.done_res));
        if (seen.read_byte !== want.read_byte)
          report_mismatch("read_byte", 16'(seen.read_byte), 16'(want.read_byte));
        if (seen.rejected !== want.rejected)
          report_mismatch("rejected", 16'(seen.rejected), 16'(want.rejected));
        if (out_tdata[15:14] !== 2'b00)
          report_mismatch("padding", 16'(out_tdata[15:14]), 16'd0);
      end
      n_results++;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (!steady && $urandom_range(0, 99) < 14) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [1:0] kind, input logic [8:0] word, input logic sda);
    tws_pkg::result_t r;
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'd0, sda, word};
    do @(posedge clk); while (!in_tready);
    r = next_pins(kind, word, sda);
    pins_due.push_back(r);
    n_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_phase_len(input logic [15:0] len);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    ph_ticks = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Plain ticks until the transfer under way has ended.
  task automatic finish_transfer();
    while (pm_mode != tws_pkg::MODE_IDLE)
      push_item(tws_pkg::KIND_TICK, 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
  endtask

  // A noise of 100 or more puts a command on every item of the transfer.
  task automatic run_transfer(input logic [1:0] start, input logic [8:0] word,
                              input int sda_pat, input int noise);
    logic [1:0] k;
    logic       s;
    push_item(start, word, 1'($urandom_range(0, 1)));
    if (start == tws_pkg::KIND_WRITE) n_writes++;
    else n_reads++;
    while (pm_mode != tws_pkg::MODE_IDLE) begin
      k = tws_pkg::KIND_TICK;
      if (noise >= 100) begin
        k = tws_pkg::KIND_READ;
      end else if ($urandom_range(0, 99) < noise) begin
        case ($urandom_range(0, 2))
          0:       k = tws_pkg::KIND_WRITE;
          1:       k = tws_pkg::KIND_READ;
          default: k = KIND_SPARE;
        endcase
      end
      s = (sda_pat < 2) ? sda_pat[0] : 1'($urandom_range(0, 1));
      push_item(k, 9'($urandom_range(0, 511)), s);
    end
  endtask

  task automatic test_reset_phase_length();
    push_item(tws_pkg::KIND_WRITE, 9'h100, 1'b0);
    n_writes++;
    repeat (205)
      push_item(tws_pkg::KIND_TICK, 9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
    write_phase_len(16'd1);
    finish_transfer();
    push_item(tws_pkg::KIND_TICK, 9'h1FF, 1'b1);
  endtask

  task automatic test_short_phases();
    write_phase_len(16'd0);
    run_transfer(tws_pkg::KIND_WRITE, 9'h1FF, 2, 0);
    push_item(tws_pkg::KIND_TICK, 9'h000, 1'b0);
    push_item(KIND_SPARE, 9'h1FF, 1'b1);
    run_transfer(tws_pkg::KIND_WRITE, 9'h000, 2, 100);
    run_transfer(tws_pkg::KIND_READ, 9'h1FF, 1, 0);
    run_transfer(tws_pkg::KIND_READ, 9'h000, 0, 100);
    write_phase_len(16'd1);
    run_transfer(tws_pkg::KIND_WRITE, 9'h155, 2, 30);
    run_transfer(tws_pkg::KIND_READ, 9'h0AA, 2, 30);
    push_item(tws_pkg::KIND_TICK, 9'h0AA, 1'b1);
  endtask

  task automatic test_backpressure();
    write_phase_len(16'd2);
    hold_cycles = 400;
    run_transfer(tws_pkg::KIND_WRITE, 9'($urandom_range(0, 511)), 2, 10);
    run_transfer(tws_pkg::KIND_READ, 9'($urandom_range(0, 511)), 2, 10);
    wait_drained();
    run_transfer(tws_pkg::KIND_READ, 9'($urandom_range(0, 511)), 2, 10);
  endtask

  task automatic test_random_transfers();
    logic [15:0] lens [4];
    int          base;
    int          noise;
    lens[0] = 16'd1;
    lens[1] = 16'd3;
    lens[2] = 16'd2;
    lens[3] = 16'($urandom_range(4, 7));
    for (int s = 0; s < 4; s++) begin
      write_phase_len(lens[s]);
      steady = (s == 1);
      base = n_items;
      while (n_items - base < 300) begin
        repeat ($urandom_range(0, 3))
          push_item($urandom_range(0, 1) ? tws_pkg::KIND_TICK : KIND_SPARE,
                    9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
        noise = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(20, 100);
        run_transfer($urandom_range(0, 1) ? tws_pkg::KIND_WRITE : tws_pkg::KIND_READ,
                     9'($urandom_range(0, 511)), 2, noise);
      end
      steady = 1'b0;
    end
  endtask

  task automatic test_longest_phase();
    write_phase_len(16'hFFFF);
    push_item(KIND_SPARE, 9'h1FF, 1'b1);
    push_item(tws_pkg::KIND_READ, 9'h000, 1'b1);
    n_reads++;
    repeat (60)
      push_item(($urandom_range(0, 99) < 2) ? tws_pkg::KIND_WRITE : tws_pkg::KIND_TICK,
                9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
    write_phase_len(16'd3);
    finish_transfer();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    ph_ticks   = tws_pkg::PHASE_TICKS_RST;
    pm_mode    = tws_pkg::MODE_IDLE;
    pm_count   = 0;
    pm_step    = tws_pkg::STEP_LOW;
    pm_bits    = 0;
    pm_shift   = '0;
    pm_scl     = 1'b0;
    pm_sda     = 1'b0;
    pm_drive   = 1'b0;
    pm_rx      = '0;
    err_cnt    = 0;
    n_items    = 0;
    n_results  = 0;
    n_writes   = 0;
    n_reads    = 0;
    n_rejects  = 0;
    hold_cycles = 0;
    steady     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_phase_length();
    test_short_phases();
    test_backpressure();
    test_random_transfers();
    test_longest_phase();

    @(negedge clk);
    in_tvalid <= 1'b0;
    for (int i = 0; i < 2000 && pins_due.size() != 0; i++) @(posedge clk);
    if (pins_due.size() != 0) report_mismatch("results missing", 16'(pins_due.size()), 16'd0);
    repeat (5) @(posedge clk);

    $display("Run covered %0d items: %0d writes and %0d reads, %0d commands refused while busy.",
             n_items, n_writes, n_reads, n_rejects);
    $display("Phase lengths 0, 1, 2, 3, a random short one, 200 and 65535 were exercised.");
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
